// File: design/shared_buffer_priority_queue_unit_defines.svh
// Assertion macros shared by the priority queue RTL.
`ifndef SHARED_BUFFER_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SHARED_BUFFER_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SBPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbpq: same-cycle check failed");
`define SBPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbpq: next-cycle check failed");
`else
`define SBPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/sbpq_pkg.sv
// Types and fixed field widths of the shared buffer priority queue.
`timescale 1ns / 1ps
`default_nettype none
package sbpq_pkg;
    localparam int ACTION_W    = 2;
    localparam int PRIO_W      = 4;
    localparam int TOPIC_W     = 8;
    localparam int WORD_W      = 32;
    localparam int SLOT_PORT_W = 5;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_RELEASE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_BAD_ARG  = 2'd2,
        STS_NOT_HELD = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [TOPIC_W-1:0] topic;
        logic [WORD_W-1:0]  cookie;
        logic [WORD_W-1:0]  handle;
        logic [WORD_W-1:0]  length;
        logic [WORD_W-1:0]  owner;
    } t_rec;

    localparam int REC_W = $bits(t_rec);
endpackage
`default_nettype wire

// File: design/sbpq_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sbpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: design/shared_buffer_priority_queue_unit.sv
// Strict priority multi-queue over a shared slot pool with a linked free list.
//
//   channel  | handshake          | direction | payload
//   ---------+--------------------+-----------+----------------------------------------
//   request  | i_valid / o_ready  | in        | action, priority, topic, cookie, ...
//   result   | o_valid / i_ready  | out       | status, slot, dequeued event record
//
// A request is accepted in ST_IDLE, which reads the link memory on enqueue and dequeue (and the record
// memory on dequeue); ST_EXEC then resolves the next pointer from the read data.
// ST_EXEC holds while the result register is still full and not taken.
// No clearing pass after reset; link entries never written read as the initial chain.
`timescale 1ns / 1ps
`default_nettype none
`include "shared_buffer_priority_queue_unit_defines.svh"
module shared_buffer_priority_queue_unit #(
    parameter int SLOT_COUNT      = 32,
    parameter int PRIORITY_LEVELS = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [sbpq_pkg::ACTION_W-1:0]        i_action,
    input  wire logic [sbpq_pkg::PRIO_W-1:0]          i_priority_req,
    input  wire logic [sbpq_pkg::TOPIC_W-1:0]         i_topic,
    input  wire logic [sbpq_pkg::WORD_W-1:0]          i_cookie,
    input  wire logic [sbpq_pkg::WORD_W-1:0]          i_message_handle,
    input  wire logic [sbpq_pkg::WORD_W-1:0]          i_message_length,
    input  wire logic [sbpq_pkg::WORD_W-1:0]          i_owner_id,
    input  wire logic [sbpq_pkg::SLOT_PORT_W-1:0]     i_slot,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output sbpq_pkg::t_status                         o_status,
    output logic      [sbpq_pkg::SLOT_PORT_W-1:0]     o_out_slot,
    output logic      [sbpq_pkg::PRIO_W-1:0]          o_out_priority,
    output logic      [sbpq_pkg::TOPIC_W-1:0]         o_out_topic,
    output logic      [sbpq_pkg::WORD_W-1:0]          o_out_cookie,
    output logic      [sbpq_pkg::WORD_W-1:0]          o_out_message_handle,
    output logic      [sbpq_pkg::WORD_W-1:0]          o_out_message_length,
    output logic      [sbpq_pkg::WORD_W-1:0]          o_out_owner_id
);
    import sbpq_pkg::*;

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int LW    = $clog2(PRIORITY_LEVELS);
    localparam int LNK_W = SW + 1;

    t_state r_state, n_state;
    logic   in_acc, exec_done;

    // free list head, per-slot flags and per-level queue state
    logic                       r_free_v;
    logic [SW-1:0]              r_free_idx;
    logic [SLOT_COUNT-1:0]      r_held;
    logic [SLOT_COUNT-1:0]      r_lnk_v;
    logic [PRIORITY_LEVELS-1:0] r_lvl_ne;
    logic [SW-1:0]              r_head [PRIORITY_LEVELS];
    logic [SW-1:0]              r_tail [PRIORITY_LEVELS];

    // request decode in ST_IDLE
    logic          any_ne, pri_ok, args_ok, rel_in_range;
    logic          is_enq, is_deq, is_rel;
    logic [LW-1:0] top_lvl, req_lvl, sel_lvl;
    logic [SW-1:0] rel_idx, sel_head, sel_tail;
    logic          sel_ne;
    t_status       n_status;
    logic          n_ok;
    logic [SW-1:0] n_slot;

    // request context held for ST_EXEC
    logic          r_is_enq, r_is_deq, r_ok, r_last, r_rd_init;
    t_status       r_status;
    logic [SW-1:0] r_slot;
    logic [LW-1:0] r_lvl;

    // memory ports
    logic             lnk_we, lnk_re, rec_we, rec_re;
    logic [SW-1:0]    lnk_waddr;
    logic [LNK_W-1:0] lnk_wdata, lnk_dout, nxt;
    logic             init_v;
    logic [REC_W-1:0] rec_dout;
    t_rec             rec_wr, rec_rd;

    logic r_out_v;

    assign is_enq = (i_action == ACT_ENQUEUE);
    assign is_deq = (i_action == ACT_DEQUEUE);
    assign is_rel = (i_action == ACT_RELEASE);

    assign any_ne = |r_lvl_ne;
    always_comb begin
        top_lvl = '0;
        for (int k = 0; k < PRIORITY_LEVELS; k++) begin
            if (r_lvl_ne[k]) begin
                top_lvl = LW'(k);
            end
        end
    end

    assign pri_ok  = (i_priority_req != '0) && (32'(i_priority_req) < PRIORITY_LEVELS);
    assign args_ok = pri_ok && (i_topic != '0) && (i_cookie != '0) &&
                     (i_message_handle != '0) && (i_message_length != '0) &&
                     (i_owner_id != '0);
    assign req_lvl      = i_priority_req[LW-1:0];
    assign rel_idx      = SW'(i_slot);
    assign rel_in_range = (32'(i_slot) < SLOT_COUNT);

    assign sel_lvl  = is_deq ? top_lvl : req_lvl;
    assign sel_head = r_head[sel_lvl];
    assign sel_tail = r_tail[sel_lvl];
    assign sel_ne   = r_lvl_ne[sel_lvl];

    always_comb begin
        n_status = STS_BAD_ARG;
        n_ok     = 1'b0;
        n_slot   = rel_idx;
        case (t_action'(i_action))
            ACT_ENQUEUE: begin
                n_slot = r_free_idx;
                if (!args_ok) begin
                    n_status = STS_BAD_ARG;
                end else if (!r_free_v) begin
                    n_status = STS_EMPTY;
                end else begin
                    n_status = STS_OK;
                    n_ok     = 1'b1;
                end
            end
            ACT_DEQUEUE: begin
                n_slot = sel_head;
                if (!any_ne) begin
                    n_status = STS_EMPTY;
                end else begin
                    n_status = STS_OK;
                    n_ok     = 1'b1;
                end
            end
            ACT_RELEASE: begin
                if (!rel_in_range) begin
                    n_status = STS_BAD_ARG;
                end else if (!r_held[rel_idx]) begin
                    n_status = STS_NOT_HELD;
                end else begin
                    n_status = STS_OK;
                    n_ok     = 1'b1;
                end
            end
            default: begin
                n_status = STS_BAD_ARG;
            end
        endcase
    end

    // link memory: append at tail on enqueue, push on free list on release
    assign lnk_we    = in_acc && n_ok && ((is_enq && sel_ne) || is_rel);
    assign lnk_waddr = is_enq ? sel_tail : rel_idx;
    assign lnk_wdata = is_enq ? {1'b1, r_free_idx} : {r_free_v, r_free_idx};
    assign lnk_re    = in_acc && n_ok && (is_enq || is_deq);

    assign rec_wr = '{prio: i_priority_req, topic: i_topic, cookie: i_cookie,
                      handle: i_message_handle, length: i_message_length,
                      owner: i_owner_id};
    assign rec_we = in_acc && n_ok && is_enq;
    assign rec_re = in_acc && n_ok && is_deq;
    assign rec_rd = t_rec'(rec_dout);

    sbpq_ram #(
        .WIDTH (LNK_W),
        .DEPTH (SLOT_COUNT)
    ) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_re    (lnk_re),
        .i_raddr (n_slot),
        .o_rdata (lnk_dout)
    );

    sbpq_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOT_COUNT)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_free_idx),
        .i_wdata (REC_W'(rec_wr)),
        .i_re    (rec_re),
        .i_raddr (sel_head),
        .o_rdata (rec_dout)
    );

    // unwritten link entries read as the initial chain
    assign init_v = (32'(r_slot) < SLOT_COUNT - 1);
    assign nxt    = r_rd_init ? {init_v, r_slot + 1'b1} : lnk_dout;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        exec_done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_EXEC: begin
                exec_done = !r_out_v || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign in_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_free_v   <= 1'b1;
            r_free_idx <= '0;
            r_held     <= '0;
            r_lnk_v    <= '0;
            r_lvl_ne   <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (lnk_we) begin
                r_lnk_v[lnk_waddr] <= 1'b1;
            end
            if (in_acc && n_ok && is_enq) begin
                r_lvl_ne[sel_lvl] <= 1'b1;
            end
            if (in_acc && n_ok && is_rel) begin
                r_free_v         <= 1'b1;
                r_free_idx       <= rel_idx;
                r_held[rel_idx]  <= 1'b0;
            end
            if (exec_done && r_ok && r_is_enq) begin
                r_free_v   <= nxt[SW];
                r_free_idx <= nxt[SW-1:0];
            end
            if (exec_done && r_ok && r_is_deq) begin
                r_held[r_slot] <= 1'b1;
                if (r_last) begin
                    r_lvl_ne[r_lvl] <= 1'b0;
                end
            end
            if (exec_done) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_is_enq  <= is_enq;
            r_is_deq  <= is_deq;
            r_ok      <= n_ok;
            r_status  <= n_status;
            r_slot    <= n_slot;
            r_lvl     <= sel_lvl;
            r_last    <= (sel_head == sel_tail);
            r_rd_init <= !r_lnk_v[n_slot];
        end
        if (in_acc && n_ok && is_enq) begin
            if (!sel_ne) begin
                r_head[sel_lvl] <= r_free_idx;
            end
            r_tail[sel_lvl] <= r_free_idx;
        end
        if (exec_done && r_ok && r_is_deq) begin
            r_head[r_lvl] <= nxt[SW-1:0];
        end
        if (exec_done) begin
            o_status             <= r_status;
            o_out_slot           <= (r_ok && (r_is_enq || r_is_deq)) ?
                                    SLOT_PORT_W'(r_slot) : '0;
            o_out_priority       <= (r_ok && r_is_deq) ? rec_rd.prio   : '0;
            o_out_topic          <= (r_ok && r_is_deq) ? rec_rd.topic  : '0;
            o_out_cookie         <= (r_ok && r_is_deq) ? rec_rd.cookie : '0;
            o_out_message_handle <= (r_ok && r_is_deq) ? rec_rd.handle : '0;
            o_out_message_length <= (r_ok && r_is_deq) ? rec_rd.length : '0;
            o_out_owner_id       <= (r_ok && r_is_deq) ? rec_rd.owner  : '0;
        end
    end

    assign o_valid = r_out_v;

    `SBPQ_ASSERT_NEXT(a_acc_to_exec, i_clk, i_rst_n, in_acc, r_state == ST_EXEC)
    `SBPQ_ASSERT_IMP(a_deq_level_live, i_clk, i_rst_n, (r_state == ST_EXEC) && r_is_deq && r_ok, r_lvl_ne[r_lvl])
    `SBPQ_ASSERT_IMP(a_free_not_held, i_clk, i_rst_n, r_free_v, !r_held[r_free_idx])
    `SBPQ_ASSERT_IMP(a_level0_empty, i_clk, i_rst_n, 1'b1, !r_lvl_ne[0])
    `SBPQ_ASSERT_NEXT(a_deq_holds_slot, i_clk, i_rst_n, exec_done && r_is_deq && r_ok, r_held[r_slot])
endmodule
`default_nettype wire

// File: sim/shared_buffer_priority_queue_checker.sv
// Predictor and scoreboard for the shared buffer priority queue request and result channels.
`timescale 1ns / 1ps
module shared_buffer_priority_queue_checker #(
    parameter int SLOT_COUNT      = 32,
    parameter int PRIORITY_LEVELS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    input  logic                                 i_req_ready,
    input  logic [sbpq_pkg::ACTION_W-1:0]        i_action,
    input  logic [sbpq_pkg::PRIO_W-1:0]          i_priority_req,
    input  logic [sbpq_pkg::TOPIC_W-1:0]         i_topic,
    input  logic [sbpq_pkg::WORD_W-1:0]          i_cookie,
    input  logic [sbpq_pkg::WORD_W-1:0]          i_message_handle,
    input  logic [sbpq_pkg::WORD_W-1:0]          i_message_length,
    input  logic [sbpq_pkg::WORD_W-1:0]          i_owner_id,
    input  logic [sbpq_pkg::SLOT_PORT_W-1:0]     i_slot,
    input  logic                                 i_rsp_valid,
    input  logic                                 i_rsp_ready,
    input  sbpq_pkg::t_status                    i_status,
    input  logic [sbpq_pkg::SLOT_PORT_W-1:0]     i_out_slot,
    input  logic [sbpq_pkg::PRIO_W-1:0]          i_out_priority,
    input  logic [sbpq_pkg::TOPIC_W-1:0]         i_out_topic,
    input  logic [sbpq_pkg::WORD_W-1:0]          i_out_cookie,
    input  logic [sbpq_pkg::WORD_W-1:0]          i_out_message_handle,
    input  logic [sbpq_pkg::WORD_W-1:0]          i_out_message_length,
    input  logic [sbpq_pkg::WORD_W-1:0]          i_out_owner_id,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output logic [SLOT_COUNT-1:0]                o_held_mask
);
    import sbpq_pkg::*;

    localparam logic [5:0] NIL = 6'h3F;
    localparam int         SW  = $clog2(SLOT_COUNT);
    localparam int         LW  = $clog2(PRIORITY_LEVELS);

    typedef struct packed {
        t_status                 status;
        logic [SLOT_PORT_W-1:0]  slot;
        t_rec                    rec;
    } t_event_result;

    logic [5:0]            free_head;
    logic [5:0]            link_next  [SLOT_COUNT];
    logic [5:0]            level_head [PRIORITY_LEVELS];
    logic [5:0]            level_tail [PRIORITY_LEVELS];
    logic [SLOT_COUNT-1:0] slot_held;
    t_rec                  slot_rec   [SLOT_COUNT];
    t_event_result         expected_results [$];
    int                    fail_count;

    assign o_held_mask = slot_held;

    function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Applies one accepted request to the queue state and returns its result.
    task automatic apply_request(output t_event_result res);
        logic [5:0]    s;
        logic [SW-1:0] si;
        logic [LW-1:0] li;
        logic [LW-1:0] dl;
        int            lvl;
        bit            found;
        res = '0;
        found = 1'b0;
        s = NIL;
        si = '0;
        li = i_priority_req[LW-1:0];
        case (i_action)
            ACT_ENQUEUE: begin
                if (i_topic == 0 || i_cookie == 0 || i_message_handle == 0 ||
                    i_message_length == 0 || i_owner_id == 0 ||
                    i_priority_req == 0 || i_priority_req >= PRIORITY_LEVELS) begin
                    res.status = STS_BAD_ARG;
                end else if (free_head == NIL) begin
                    res.status = STS_EMPTY;
                end else begin
                    s = free_head;
                    si = s[SW-1:0];
                    free_head = link_next[si];
                    slot_rec[si] = '{prio: i_priority_req, topic: i_topic, cookie: i_cookie,
                                     handle: i_message_handle, length: i_message_length,
                                     owner: i_owner_id};
                    slot_held[si] = 1'b0;
                    link_next[si] = NIL;
                    if (level_head[li] == NIL) begin
                        level_head[li] = s;
                    end else begin
                        link_next[level_tail[li][SW-1:0]] = s;
                    end
                    level_tail[li] = s;
                    res.status = STS_OK;
                    res.slot = s[SLOT_PORT_W-1:0];
                end
            end
            ACT_DEQUEUE: begin
                for (lvl = PRIORITY_LEVELS - 1; lvl > 0 && !found; lvl--) begin
                    dl = LW'(lvl);
                    if (level_head[dl] != NIL) begin
                        s = level_head[dl];
                        si = s[SW-1:0];
                        level_head[dl] = link_next[si];
                        if (level_head[dl] == NIL) begin
                            level_tail[dl] = NIL;
                        end
                        link_next[si] = NIL;
                        slot_held[si] = 1'b1;
                        res.status = STS_OK;
                        res.slot = s[SLOT_PORT_W-1:0];
                        res.rec = slot_rec[si];
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    res.status = STS_EMPTY;
                end
            end
            ACT_RELEASE: begin
                s = {1'b0, i_slot};
                si = s[SW-1:0];
                if (s >= SLOT_COUNT) begin
                    res.status = STS_BAD_ARG;
                end else if (!slot_held[si]) begin
                    res.status = STS_NOT_HELD;
                end else begin
                    slot_held[si] = 1'b0;
                    slot_rec[si].topic = '0;
                    link_next[si] = free_head;
                    free_head = s;
                    res.status = STS_OK;
                end
            end
            default: begin
                res.status = STS_BAD_ARG;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_event_result want;
        if (!i_rst_n) begin
            free_head = '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                link_next[i] = (i < SLOT_COUNT - 1) ? 6'(i + 1) : NIL;
                slot_rec[i] = '0;
            end
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                level_head[i] = NIL;
                level_tail[i] = NIL;
            end
            slot_held = '0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result expected none actual status %0d slot %0d",
                             $time, i_status, i_out_slot);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    fail_count += field_mismatch("status", 32'(want.status), 32'(i_status))
                        + field_mismatch("out_slot", 32'(want.slot), 32'(i_out_slot))
                        + field_mismatch("out_priority", 32'(want.rec.prio),
                                         32'(i_out_priority))
                        + field_mismatch("out_topic", 32'(want.rec.topic), 32'(i_out_topic))
                        + field_mismatch("out_cookie", want.rec.cookie, i_out_cookie)
                        + field_mismatch("out_message_handle", want.rec.handle,
                                         i_out_message_handle)
                        + field_mismatch("out_message_length", want.rec.length,
                                         i_out_message_length)
                        + field_mismatch("out_owner_id", want.rec.owner, i_out_owner_id);
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(want);
                expected_results.push_back(want);
            end
        end
        o_fail_count = fail_count;
        o_pending = expected_results.size();
    end
endmodule

// File: sim/shared_buffer_priority_queue_unit_tb.sv
// Testbench top for the shared buffer priority queue: clock, reset, requests, verdict.
`timescale 1ns / 1ps
module shared_buffer_priority_queue_unit_tb;
    import sbpq_pkg::*;

    localparam int         SLOT_COUNT      = 32;
    localparam int         PRIORITY_LEVELS = 8;
    localparam int         RANDOM_ITEMS    = 550;
    localparam logic [1:0] ACT_UNKNOWN     = 2'd3;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} t_phase;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    logic [ACTION_W-1:0]      req_action = '0;
    logic [PRIO_W-1:0]        req_priority = '0;
    logic [TOPIC_W-1:0]       req_topic = '0;
    logic [WORD_W-1:0]        req_cookie = '0;
    logic [WORD_W-1:0]        req_handle = '0;
    logic [WORD_W-1:0]        req_length = '0;
    logic [WORD_W-1:0]        req_owner = '0;
    logic [SLOT_PORT_W-1:0]   req_slot = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    t_status                  rsp_status;
    logic [SLOT_PORT_W-1:0]   rsp_slot;
    logic [PRIO_W-1:0]        rsp_priority;
    logic [TOPIC_W-1:0]       rsp_topic;
    logic [WORD_W-1:0]        rsp_cookie;
    logic [WORD_W-1:0]        rsp_handle;
    logic [WORD_W-1:0]        rsp_length;
    logic [WORD_W-1:0]        rsp_owner;
    int                       fail_count;
    int                       pending;
    logic [SLOT_COUNT-1:0]    held_mask;
    int                       burst_left = 0;
    int                       ready_cycle = 0;

    shared_buffer_priority_queue_unit #(
        .SLOT_COUNT(SLOT_COUNT),
        .PRIORITY_LEVELS(PRIORITY_LEVELS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(req_valid),
        .o_ready(req_ready),
        .i_action(req_action),
        .i_priority_req(req_priority),
        .i_topic(req_topic),
        .i_cookie(req_cookie),
        .i_message_handle(req_handle),
        .i_message_length(req_length),
        .i_owner_id(req_owner),
        .i_slot(req_slot),
        .o_valid(rsp_valid),
        .i_ready(rsp_ready),
        .o_status(rsp_status),
        .o_out_slot(rsp_slot),
        .o_out_priority(rsp_priority),
        .o_out_topic(rsp_topic),
        .o_out_cookie(rsp_cookie),
        .o_out_message_handle(rsp_handle),
        .o_out_message_length(rsp_length),
        .o_out_owner_id(rsp_owner)
    );

    shared_buffer_priority_queue_checker #(
        .SLOT_COUNT(SLOT_COUNT),
        .PRIORITY_LEVELS(PRIORITY_LEVELS)
    ) checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(req_valid),
        .i_req_ready(req_ready),
        .i_action(req_action),
        .i_priority_req(req_priority),
        .i_topic(req_topic),
        .i_cookie(req_cookie),
        .i_message_handle(req_handle),
        .i_message_length(req_length),
        .i_owner_id(req_owner),
        .i_slot(req_slot),
        .i_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready),
        .i_status(rsp_status),
        .i_out_slot(rsp_slot),
        .i_out_priority(rsp_priority),
        .i_out_topic(rsp_topic),
        .i_out_cookie(rsp_cookie),
        .i_out_message_handle(rsp_handle),
        .i_out_message_length(rsp_length),
        .i_out_owner_id(rsp_owner),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_held_mask(held_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side stalls on its own schedule, rotating through always, random, sparse and mostly ready.
    always @(negedge i_clk) begin
        case ((ready_cycle / 97) % 4)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= (ready_cycle % 5 == 0);
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
        endcase
        ready_cycle++;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 15))
            0:       w = '1;
            1:       w = 1;
            default: w = $urandom;
        endcase
        if (w == 0) begin
            w = 1;
        end
        return w;
    endfunction

    // Drives one request at a falling edge and holds it until accepted.
    task automatic send(input logic [ACTION_W-1:0] act, input logic [PRIO_W-1:0] prio,
                        input logic [TOPIC_W-1:0] topic, input logic [WORD_W-1:0] cookie,
                        input logic [WORD_W-1:0] handle, input logic [WORD_W-1:0] length,
                        input logic [WORD_W-1:0] owner, input logic [SLOT_PORT_W-1:0] slot);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        req_action   <= act;
        req_priority <= prio;
        req_topic    <= topic;
        req_cookie   <= cookie;
        req_handle   <= handle;
        req_length   <= length;
        req_owner    <= owner;
        req_slot     <= slot;
        req_valid    <= 1'b1;
        do @(posedge i_clk); while (!req_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [ACTION_W-1:0]    act;
        logic [PRIO_W-1:0]      prio;
        logic [TOPIC_W-1:0]     topic;
        logic [WORD_W-1:0]      cookie;
        logic [WORD_W-1:0]      handle;
        logic [WORD_W-1:0]      length;
        logic [WORD_W-1:0]      owner;
        logic [SLOT_PORT_W-1:0] slot;
        t_phase                 phase;
        int                     phase_left;
        int                     roll;

        phase = PH_FILL;
        phase_left = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty queues, free slot, unknown action, each bad argument, then enqueue, dequeue, release
        send(ACT_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_RELEASE, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_UNKNOWN, '1, '1, '1, '1, '1, '1, '1);
        for (int k = 0; k < 8; k++) begin
            prio = 3;
            topic = 8'h5A;
            cookie = 32'h1234_5678;
            handle = 32'h0BAD_F00D;
            length = 32'd17;
            owner = 32'h7700_0001;
            case (k)
                0:       prio = 0;
                1:       prio = PRIO_W'(PRIORITY_LEVELS);
                2:       prio = '1;
                3:       topic = 0;
                4:       cookie = 0;
                5:       handle = 0;
                6:       length = 0;
                default: owner = 0;
            endcase
            send(ACT_ENQUEUE, prio, topic, cookie, handle, length, owner, '1);
        end
        send(ACT_ENQUEUE, PRIO_W'(PRIORITY_LEVELS - 1), '1, '1, '1, '1, '1, 0);
        send(ACT_ENQUEUE, 1, 1, 1, 1, 1, 1, 0);
        send(ACT_ENQUEUE, PRIO_W'(PRIORITY_LEVELS - 1), 8'h80, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 0);
        send(ACT_RELEASE, 0, 0, 0, 0, 0, 0, 5'd31);
        send(ACT_RELEASE, 0, 0, 0, 0, 0, 0, 5'd1);
        repeat (4) send(ACT_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_RELEASE, 0, 0, 0, 0, 0, 0, 5'd2);
        send(ACT_RELEASE, 0, 0, 0, 0, 0, 0, 5'd2);
        send(ACT_ENQUEUE, 2, 8'h01, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 0);
        wait_for_results();

        // random: phases of filling, draining, mixed traffic and noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    wait_for_results();
                end
                roll = $urandom_range(0, 99);
                phase = (roll < 35) ? PH_FILL : (roll < 65) ? PH_DRAIN :
                        (roll < 85) ? PH_MIXED : PH_NOISE;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            prio = PRIO_W'($urandom_range(1, PRIORITY_LEVELS - 1));
            topic = TOPIC_W'($urandom_range(1, 255));
            cookie = rand_word();
            handle = rand_word();
            length = rand_word();
            owner = rand_word();
            slot = SLOT_PORT_W'($urandom_range(0, SLOT_COUNT - 1));
            roll = $urandom_range(0, 99);
            case (phase)
                PH_FILL:  act = (roll < 75) ? ACT_ENQUEUE : (roll < 90) ? ACT_DEQUEUE
                                                                         : ACT_RELEASE;
                PH_DRAIN: act = (roll < 15) ? ACT_ENQUEUE : (roll < 55) ? ACT_DEQUEUE
                                                                         : ACT_RELEASE;
                PH_MIXED: act = (roll < 40) ? ACT_ENQUEUE : (roll < 70) ? ACT_DEQUEUE
                                                                         : ACT_RELEASE;
                default: begin
                    act = ACTION_W'($urandom_range(0, 3));
                    prio = PRIO_W'($urandom_range(0, 15));
                    topic = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
                    cookie = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom);
                    handle = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom);
                    length = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom);
                    owner = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom);
                end
            endcase
            if (phase != PH_NOISE && act == ACT_ENQUEUE && $urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 5))
                    0:       prio = 0;
                    1:       topic = 0;
                    2:       cookie = 0;
                    3:       handle = 0;
                    4:       length = 0;
                    default: owner = 0;
                endcase
            end
            // mostly release slots that are actually held
            if (phase != PH_NOISE && act == ACT_RELEASE && held_mask != 0 &&
                $urandom_range(0, 99) < 85) begin
                while (!held_mask[slot]) slot++;
            end
            send(act, prio, topic, cookie, handle, length, owner, slot);
        end

        wait_for_results();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
